@@ hdl/spdc_pkg.sv @@
// ----------------------------------------------------------------------------
// spdc_pkg: shared types, constants and the digest function
// Packet layout constants, the result record and the byte-wide LFSR digest
// step used by the sensor packet decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package spdc_pkg;

    // Packet layout
    localparam int unsigned PAYLOAD_BYTES = 5;
    localparam int unsigned IDX_W         = $clog2(PAYLOAD_BYTES + 1);
    localparam int unsigned HELD_W        = $clog2(PAYLOAD_BYTES);

    // Digest constants
    localparam logic [7:0] MASK_INIT = 8'h7C;
    localparam logic [7:0] ACC_INIT  = 8'h64;
    localparam logic [7:0] MASK_TAP  = 8'h18;

    // Field checks
    localparam logic [7:0] TYPE_A       = 8'h45;
    localparam logic [7:0] TYPE_B       = 8'h46;
    localparam logic [7:0] HUMIDITY_MAX = 8'd100;
    localparam logic [7:0] BATT_MASK    = 8'b1000_0000;
    localparam logic [7:0] CHAN_MASK    = 8'b0111_0000;
    localparam logic [7:0] TEMP_HI_MASK = 8'b0000_1111;

    // Temperature scaling: divide by ten through a reciprocal multiply
    localparam logic [12:0] TEMP_OFFSET = 13'd400;
    localparam logic [12:0] DIV10_RECIP = 13'd6554;
    localparam int unsigned DIV10_SHIFT = 16;

    // Configuration register map
    localparam logic REG_MAX_CHANNEL = 1'b0;
    localparam logic [3:0] MAX_CHANNEL_RST = 4'd8;

    typedef struct packed {
        logic [7:0] mask;
        logic [7:0] acc;
    } t_digest;

    typedef struct packed {
        logic              humidity_valid;
        logic              channel_valid;
        logic              type_known;
        logic              checksum_ok;
        logic [7:0]        digest;
        logic [7:0]        humidity;
        logic signed [9:0] temp_f_whole;
        logic [11:0]       temp_code;
        logic [3:0]        channel;
        logic              low_battery;
        logic [7:0]        link_id;
        logic [7:0]        kind_code;
    } t_result;

    // One byte of the digest, data bits taken MSB first
    function automatic t_digest digest_byte(input t_digest cur, input logic [7:0] b);
        t_digest    res;
        logic [7:0] m;
        logic [7:0] a;
        logic       out_bit;
        m = cur.mask;
        a = cur.acc;
        for (int k = 7; k >= 0; k--) begin
            out_bit = m[0];
            m = {m[0], m[7:1]};
            if (out_bit) begin
                m = m ^ MASK_TAP;
            end
            if (b[k]) begin
                a = a ^ m;
            end
        end
        res.mask = m;
        res.acc  = a;
        return res;
    endfunction

endpackage

`default_nettype wire

@@ hdl/spdc_unpack.sv @@
// ----------------------------------------------------------------------------
// spdc_unpack: field unpacking and checks
// Splits the held payload bytes into the result fields, scales the raw
// temperature to whole Fahrenheit and raises the validity flags.
// ----------------------------------------------------------------------------
`default_nettype none

module spdc_unpack (
    input  wire logic [7:0]       i_byte0,
    input  wire logic [7:0]       i_byte1,
    input  wire logic [7:0]       i_byte2,
    input  wire logic [7:0]       i_byte3,
    input  wire logic [7:0]       i_byte4,
    input  wire logic [7:0]       i_check_byte,
    input  wire logic [7:0]       i_digest,
    input  wire logic [3:0]       i_max_channel,
    output spdc_pkg::t_result     o_result
);
    import spdc_pkg::*;

    logic [3:0]         w_channel;
    logic [11:0]        w_temp_code;
    logic signed [12:0] w_diff;
    logic               w_neg;
    logic [11:0]        w_mag;
    logic [24:0]        w_prod;
    logic [8:0]         w_quot;
    logic [9:0]         w_fahr;

    // Unpack byte 2 into battery, channel and upper temperature bits
    assign w_channel   = {1'b0, 3'((i_byte2 & CHAN_MASK) >> 4)} + 4'd1;
    assign w_temp_code = {4'(i_byte2 & TEMP_HI_MASK), i_byte3};

    // Offset, then divide the magnitude by ten and restore the sign
    assign w_diff = $signed({1'b0, w_temp_code}) - $signed(TEMP_OFFSET);
    assign w_neg  = w_diff[12];
    assign w_mag  = w_neg ? 12'(-w_diff) : w_diff[11:0];
    assign w_prod = {13'd0, w_mag} * {12'd0, DIV10_RECIP};
    assign w_quot = w_prod[DIV10_SHIFT +: 9];
    assign w_fahr = w_neg ? (10'd0 - {1'b0, w_quot}) : {1'b0, w_quot};

    // Assemble the result record
    always_comb begin
        o_result.kind_code      = i_byte0;
        o_result.link_id        = i_byte1;
        o_result.low_battery    = |(i_byte2 & BATT_MASK);
        o_result.channel        = w_channel;
        o_result.temp_code      = w_temp_code;
        o_result.temp_f_whole   = $signed(w_fahr);
        o_result.humidity       = i_byte4;
        o_result.digest         = i_digest;
        o_result.checksum_ok    = (i_check_byte == i_digest);
        o_result.type_known     = (i_byte0 == TYPE_A) || (i_byte0 == TYPE_B);
        o_result.channel_valid  = (w_channel <= i_max_channel);
        o_result.humidity_valid = (i_byte4 <= HUMIDITY_MAX);
    end

endmodule

`default_nettype wire

@@ hdl/sensor_packet_decode_check.sv @@
// ----------------------------------------------------------------------------
// sensor_packet_decode_check: six-byte sensor packet decoder and checker
// Takes packet bytes one item at a time, runs the LFSR digest over the
// payload and emits one decoded result item on each check byte.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream: one packet byte per item in s_axis_tdata; s_axis_tuser high
//   marks byte 0 of a packet and drops any partial packet. Bytes 0 to 4 are
//   payload, byte 5 is the check byte. After a check byte the next item is
//   taken as byte 0 even without s_axis_tuser.
//   Output stream: one result item per check byte, no item for payload bytes.
//   Configuration: max_channel at byte address 0 over the APB-style port.
//   Path: an accepted item enters the input register, and the result of a
//   check byte is then loaded from there into the output register, which
//   drives m_axis_tvalid; a full output register holds the check byte back.
//   Throughput: one item per cycle while not stalled; the eight digest bit
//   steps unroll into a shallow XOR network from input to state registers.
//   Stall: while the output register is full and m_axis_tready is low, a
//   check byte waits in the input register and s_axis_tready drops; payload
//   bytes still flow.
//   Reset: clears the index, the digest, both valid flags and sets
//   max_channel to 8. Held bytes are not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module sensor_packet_decode_check (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // Input stream
    input  wire logic        s_axis_tvalid,
    output      logic        s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  wire logic        s_axis_tuser,   // [0] packet_start
    // Output stream
    output      logic        m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // [7:0] kind_code, [15:8] link_id, [16] low_battery, [20:17] channel,
    // [32:21] temp_code, [42:33] temp_f_whole, [50:43] humidity,
    // [58:51] digest, [59] checksum_ok, [60] type_known, [61] channel_valid,
    // [62] humidity_valid, [63] zero
    output      logic [63:0] m_axis_tdata,
    // Configuration port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output      logic [31:0] prdata,
    output      logic        pready
);
    import spdc_pkg::*;

    // Configuration
    logic [3:0]       r_max_channel;

    // Input register
    logic             r_in_valid;
    logic [7:0]       r_in_byte;
    logic             r_in_start;

    // Decoder state
    logic [IDX_W-1:0] r_idx;
    logic [7:0]       r_mask;
    logic [7:0]       r_acc;
    logic [7:0]       r_held [PAYLOAD_BYTES];

    // Output register
    logic             r_out_valid;
    t_result          r_result;

    logic [IDX_W-1:0] w_idx;
    t_digest          w_cur;
    t_digest          w_next;
    logic             w_payload;
    logic             w_out_free;
    logic             w_adv;
    logic             w_load;
    t_result          w_result;

    // Configuration writes and reads
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_MAX_CHANNEL) ? {28'd0, r_max_channel} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_channel <= MAX_CHANNEL_RST;
        end else if (psel && penable && pwrite && pready && paddr[2] == REG_MAX_CHANNEL) begin
            r_max_channel <= pwdata[3:0];
        end
    end

    // Effective state for the item in the input register
    assign w_idx        = r_in_start ? '0 : r_idx;
    assign w_cur.mask   = r_in_start ? MASK_INIT : r_mask;
    assign w_cur.acc    = r_in_start ? ACC_INIT : r_acc;
    assign w_next       = digest_byte(w_cur, r_in_byte);
    assign w_payload    = (w_idx < IDX_W'(PAYLOAD_BYTES));

    // Handshake: payload bytes always advance, a check byte needs room
    assign w_out_free    = !r_out_valid || m_axis_tready;
    assign w_adv         = r_in_valid && (w_payload || w_out_free);
    assign w_load        = w_adv && !w_payload;
    assign s_axis_tready = !r_in_valid || w_adv;

    // Capture the incoming item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_byte  <= s_axis_tdata;
            r_in_start <= s_axis_tuser;
        end
    end

    // Advance index and digest, restart after the check byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx  <= '0;
            r_mask <= MASK_INIT;
            r_acc  <= ACC_INIT;
        end else if (w_adv) begin
            if (w_payload) begin
                r_idx  <= w_idx + IDX_W'(1);
                r_mask <= w_next.mask;
                r_acc  <= w_next.acc;
            end else begin
                r_idx  <= '0;
                r_mask <= MASK_INIT;
                r_acc  <= ACC_INIT;
            end
        end
    end

    // Hold payload bytes
    always_ff @(posedge i_clk) begin
        if (w_adv && w_payload) begin
            r_held[w_idx[HELD_W-1:0]] <= r_in_byte;
        end
    end

    spdc_unpack u_unpack (
        .i_byte0       (r_held[0]),
        .i_byte1       (r_held[1]),
        .i_byte2       (r_held[2]),
        .i_byte3       (r_held[3]),
        .i_byte4       (r_held[4]),
        .i_check_byte  (r_in_byte),
        .i_digest      (w_cur.acc),
        .i_max_channel (r_max_channel),
        .o_result      (w_result)
    );

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_result <= w_result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {1'b0, r_result.humidity_valid, r_result.channel_valid,
                            r_result.type_known, r_result.checksum_ok, r_result.digest,
                            r_result.humidity, r_result.temp_f_whole, r_result.temp_code,
                            r_result.channel, r_result.low_battery, r_result.link_id,
                            r_result.kind_code};

`ifndef SYNTHESIS
    // Index never passes the check byte position
    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_idx <= IDX_W'(PAYLOAD_BYTES))
        else $error("byte index out of range");

    // A cleared index always comes with a restarted digest
    a_idx_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_idx == '0) |-> (r_mask == MASK_INIT && r_acc == ACC_INIT))
        else $error("digest not restarted with index");

    // Never overwrite a result that is still waiting
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_load && r_out_valid && !m_axis_tready))
        else $error("pending result overwritten");

    // A new result only follows a check byte at the last index
    a_load_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load |-> (!r_in_start && r_idx == IDX_W'(PAYLOAD_BYTES)))
        else $error("result loaded without a complete packet");
`endif

endmodule

`default_nettype wire
